FILE: rtl/dpdt_pkg.sv
// Shared types and constants for the depth pixel deprojection table.
// Used by dpdt_lane, dpdt_ram users and depth_pixel_deproject_table.
`timescale 1ns / 1ps

package dpdt_pkg;

    typedef enum logic {
        ACT_PIXEL = 1'b0,
        ACT_QUERY = 1'b1
    } action_t;

    typedef enum logic [1:0] {
        STATUS_OK        = 2'd0,
        STATUS_NOT_READY = 2'd1,
        STATUS_BAD_INDEX = 2'd2
    } status_t;

    typedef enum logic [2:0] {
        REG_INV_FOCAL_X = 3'd0,
        REG_INV_FOCAL_Y = 3'd1,
        REG_CENTER_X    = 3'd2,
        REG_CENTER_Y    = 3'd3,
        REG_CROP_LEFT   = 3'd4,
        REG_CROP_TOP    = 3'd5
    } reg_index_t;

    typedef struct packed {
        logic [31:0] x;
        logic [31:0] y;
        logic [15:0] z;
    } entry_t;

    localparam int ENTRY_W = $bits(entry_t);

    // Deprojection pipeline depth, from accepted pixel to lane result register
    localparam int LANE_LATENCY = 4;

    localparam logic [23:0] INV_FOCAL_X_RST = 24'd27962;
    localparam logic [23:0] INV_FOCAL_Y_RST = 24'd27962;
    localparam logic [15:0] CENTER_X_RST    = 16'd5120;
    localparam logic [15:0] CENTER_Y_RST    = 16'd3840;
    localparam logic [11:0] CROP_LEFT_RST   = 12'd208;
    localparam logic [11:0] CROP_TOP_RST    = 12'd21;

    localparam logic [9:0]  MM_TO_UM   = 10'd1000;
    localparam logic [65:0] ROUND_HALF = 66'd1 << 27;

endpackage

FILE: rtl/dpdt_ram.sv
// Generic simple dual-port RAM: one write port, one read port, registered read.
// No dependencies.
`timescale 1ns / 1ps

module dpdt_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                                  clk,
    input  logic                                  wr_en,
    input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] wr_addr,
    input  logic [WIDTH-1:0]                      wr_data,
    input  logic                                  rd_en,
    input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] rd_addr,
    output logic [WIDTH-1:0]                      rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        if (rd_en)
        begin
            rd_data <= mem[rd_addr];
        end
    end

endmodule

FILE: rtl/dpdt_lane.sv
// One axis of the pinhole deprojection: (16*coord - centre) * inv_focal * z in
// micrometres, rounded and saturated, over four register stages. Uses dpdt_pkg.
`timescale 1ns / 1ps

module dpdt_lane (
    input  logic        clk,
    input  logic [11:0] coord,
    input  logic [15:0] center,
    input  logic [23:0] inv_focal,
    input  logic [15:0] depth,
    output logic [31:0] result
);

    logic signed [16:0] diff;
    logic [15:0]        absd_next;
    logic [15:0]        absd_reg;
    logic               neg1_reg;
    logic [15:0]        z1_reg;
    logic [31:0]        prod_reg;
    logic               neg2_reg;
    logic [33:0]        k_reg;
    logic [48:0]        lo_reg;
    logic [48:0]        hi_reg;
    logic               neg3_reg;
    logic [65:0]        sum;
    logic [37:0]        mag;
    logic [31:0]        result_next;
    logic [31:0]        result_reg;

    assign diff      = signed'({1'b0, coord, 4'b0000}) - signed'({1'b0, center});
    assign absd_next = diff[16] ? 16'(-diff) : diff[15:0];

    assign sum = 66'(lo_reg) + {hi_reg, 17'd0} + dpdt_pkg::ROUND_HALF;
    assign mag = sum[65:28];

    always_comb
    begin
        if (neg3_reg)
        begin
            if (mag >= 38'h0080000000)
                result_next = 32'h8000_0000;
            else
                result_next = 32'd0 - mag[31:0];
        end
        else
        begin
            if (mag > 38'h007FFFFFFF)
                result_next = 32'h7FFF_FFFF;
            else
                result_next = mag[31:0];
        end
    end

    always_ff @(posedge clk)
    begin
        k_reg      <= 34'(inv_focal) * 34'(dpdt_pkg::MM_TO_UM);
        absd_reg   <= absd_next;
        neg1_reg   <= diff[16];
        z1_reg     <= depth;
        prod_reg   <= 32'(absd_reg) * 32'(z1_reg);
        neg2_reg   <= neg1_reg;
        lo_reg     <= 49'(prod_reg) * 49'(k_reg[16:0]);
        hi_reg     <= 49'(prod_reg) * 49'(k_reg[33:17]);
        neg3_reg   <= neg2_reg;
        result_reg <= result_next;
    end

    assign result = result_reg;

endmodule

FILE: rtl/depth_pixel_deproject_table.sv
// Depth pixels inside a square crop window are back-projected with the pinhole
// model and stored column-major in one on-chip table RAM (x, y, z per entry);
// a query reads a stored point back. A depth pixel is taken every clock and
// reaches the table through the deprojection pipeline. A query is taken only
// once pending table writes have drained, the previous read is done and the
// last result has been taken; a not-ready or bad-index answer is loaded
// straight into the result register, while a table read passes first through
// the table's single registered read port. Table contents are undefined after
// reset until written; there is no clearing pass.
// Depends on dpdt_pkg, dpdt_lane and dpdt_ram.
`timescale 1ns / 1ps

module depth_pixel_deproject_table #(
    parameter int CROP_SIZE = 224
) (
    input  logic        clk,
    input  logic        rst_n,

    input  logic        cfg_write,
    input  logic [2:0]  cfg_index,
    input  logic [23:0] cfg_data,

    input  logic        in_valid,
    output logic        in_ready,
    input  logic        action,
    input  logic [11:0] pixel_col,
    input  logic [11:0] pixel_row,
    input  logic [15:0] depth_mm,
    input  logic [9:0]  query_col_offset,
    input  logic [9:0]  query_row_offset,

    output logic        out_valid,
    input  logic        out_ready,
    output logic [1:0]  status,
    output logic        point_valid,
    output logic [31:0] x_um,
    output logic [31:0] y_um,
    output logic [15:0] z_mm
);

    localparam int TABLE_LEN = CROP_SIZE * CROP_SIZE;
    localparam int AW        = (TABLE_LEN > 1) ? $clog2(TABLE_LEN) : 1;
    localparam int QW        = $clog2(1024 * CROP_SIZE + 1024);
    localparam int LAT       = dpdt_pkg::LANE_LATENCY;

    logic [23:0] inv_focal_x_reg;
    logic [23:0] inv_focal_y_reg;
    logic [15:0] center_x_reg;
    logic [15:0] center_y_reg;
    logic [11:0] crop_left_reg;
    logic [11:0] crop_top_reg;

    logic [12:0] dc;
    logic [12:0] dr;
    logic        in_window;
    logic        corner;
    logic [AW-1:0] pix_idx;
    logic        in_take;
    logic        pixel_take;
    logic        query_take;
    logic        query_open;

    logic [LAT-1:0] pix_valid_reg;
    logic [LAT-1:0] pix_valid_next;
    logic [AW-1:0]  pix_idx_reg [LAT];
    logic [15:0]    pix_z_reg   [LAT];

    logic [31:0] lane_x;
    logic [31:0] lane_y;
    dpdt_pkg::entry_t wr_entry;
    dpdt_pkg::entry_t rd_entry;
    logic [dpdt_pkg::ENTRY_W-1:0] rd_bits;

    logic [QW-1:0] q_idx;
    logic          q_in_range;

    logic ready_flag_reg;
    logic ready_flag_next;
    logic rd_pending_reg;
    logic rd_pending_next;
    logic out_valid_reg;
    logic out_valid_next;
    dpdt_pkg::status_t status_reg;
    dpdt_pkg::status_t status_next;
    logic        point_valid_reg;
    logic        point_valid_next;
    logic [31:0] x_um_reg;
    logic [31:0] x_um_next;
    logic [31:0] y_um_reg;
    logic [31:0] y_um_next;
    logic [15:0] z_mm_reg;
    logic [15:0] z_mm_next;
    logic        out_load;

    // Configuration registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            inv_focal_x_reg <= dpdt_pkg::INV_FOCAL_X_RST;
            inv_focal_y_reg <= dpdt_pkg::INV_FOCAL_Y_RST;
            center_x_reg    <= dpdt_pkg::CENTER_X_RST;
            center_y_reg    <= dpdt_pkg::CENTER_Y_RST;
            crop_left_reg   <= dpdt_pkg::CROP_LEFT_RST;
            crop_top_reg    <= dpdt_pkg::CROP_TOP_RST;
        end
        else if (cfg_write)
        begin
            case (dpdt_pkg::reg_index_t'(cfg_index))
                dpdt_pkg::REG_INV_FOCAL_X: inv_focal_x_reg <= cfg_data;
                dpdt_pkg::REG_INV_FOCAL_Y: inv_focal_y_reg <= cfg_data;
                dpdt_pkg::REG_CENTER_X:    center_x_reg    <= cfg_data[15:0];
                dpdt_pkg::REG_CENTER_Y:    center_y_reg    <= cfg_data[15:0];
                dpdt_pkg::REG_CROP_LEFT:   crop_left_reg   <= cfg_data[11:0];
                dpdt_pkg::REG_CROP_TOP:    crop_top_reg    <= cfg_data[11:0];
                default: ;
            endcase
        end
    end

    // Request handshake
    assign query_open = ~|pix_valid_reg && !rd_pending_reg && !out_valid_reg;
    assign in_ready   = (dpdt_pkg::action_t'(action) == dpdt_pkg::ACT_PIXEL) || query_open;
    assign in_take    = in_valid && in_ready;

    // Crop window and table index of a depth pixel
    assign dc = {1'b0, pixel_col} - {1'b0, crop_left_reg};
    assign dr = {1'b0, pixel_row} - {1'b0, crop_top_reg};
    assign in_window = !dc[12] && !dr[12]
                     && (dc[11:0] < 12'(CROP_SIZE)) && (dr[11:0] < 12'(CROP_SIZE));
    assign corner    = (dc[11:0] == 12'(CROP_SIZE - 1)) && (dr[11:0] == 12'(CROP_SIZE - 1));
    assign pix_idx   = AW'(dc[11:0]) * AW'(CROP_SIZE) + AW'(dr[11:0]);

    assign pixel_take = in_take && (dpdt_pkg::action_t'(action) == dpdt_pkg::ACT_PIXEL)
                      && in_window;
    assign query_take = in_take && (dpdt_pkg::action_t'(action) == dpdt_pkg::ACT_QUERY);

    // Table index of a query
    assign q_idx      = QW'(query_col_offset) * QW'(CROP_SIZE) + QW'(query_row_offset);
    assign q_in_range = q_idx < QW'(TABLE_LEN);

    dpdt_lane u_lane_x (
        .clk       (clk),
        .coord     (pixel_col),
        .center    (center_x_reg),
        .inv_focal (inv_focal_x_reg),
        .depth     (depth_mm),
        .result    (lane_x)
    );

    dpdt_lane u_lane_y (
        .clk       (clk),
        .coord     (pixel_row),
        .center    (center_y_reg),
        .inv_focal (inv_focal_y_reg),
        .depth     (depth_mm),
        .result    (lane_y)
    );

    // Track pixels through the deprojection pipeline
    assign pix_valid_next = {pix_valid_reg[LAT-2:0], pixel_take};

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            pix_valid_reg <= '0;
        else
            pix_valid_reg <= pix_valid_next;
    end

    always_ff @(posedge clk)
    begin
        pix_idx_reg[0] <= pix_idx;
        pix_z_reg[0]   <= depth_mm;
        for (int i = 1; i < LAT; i++)
        begin
            pix_idx_reg[i] <= pix_idx_reg[i-1];
            pix_z_reg[i]   <= pix_z_reg[i-1];
        end
    end

    assign wr_entry.x = lane_x;
    assign wr_entry.y = lane_y;
    assign wr_entry.z = pix_z_reg[LAT-1];

    dpdt_ram #(
        .WIDTH (dpdt_pkg::ENTRY_W),
        .DEPTH (TABLE_LEN)
    ) u_table (
        .clk     (clk),
        .wr_en   (pix_valid_reg[LAT-1]),
        .wr_addr (pix_idx_reg[LAT-1]),
        .wr_data (wr_entry),
        .rd_en   (query_take),
        .rd_addr (q_idx[AW-1:0]),
        .rd_data (rd_bits)
    );

    assign rd_entry = dpdt_pkg::entry_t'(rd_bits);

    // Ready flag, read tracking and result register
    always_comb
    begin
        ready_flag_next  = ready_flag_reg;
        rd_pending_next  = 1'b0;
        out_valid_next   = out_valid_reg && !out_ready;
        out_load         = 1'b0;
        status_next      = status_reg;
        point_valid_next = point_valid_reg;
        x_um_next        = x_um_reg;
        y_um_next        = y_um_reg;
        z_mm_next        = z_mm_reg;

        if (pixel_take && corner)
            ready_flag_next = 1'b1;

        if (query_take)
        begin
            if (!ready_flag_reg)
            begin
                out_valid_next   = 1'b1;
                out_load         = 1'b1;
                status_next      = dpdt_pkg::STATUS_NOT_READY;
                point_valid_next = 1'b0;
                x_um_next        = '0;
                y_um_next        = '0;
                z_mm_next        = '0;
            end
            else if (!q_in_range)
            begin
                out_valid_next   = 1'b1;
                out_load         = 1'b1;
                status_next      = dpdt_pkg::STATUS_BAD_INDEX;
                point_valid_next = 1'b0;
                x_um_next        = '0;
                y_um_next        = '0;
                z_mm_next        = '0;
            end
            else
            begin
                rd_pending_next = 1'b1;
                ready_flag_next = 1'b0;
            end
        end

        if (rd_pending_reg)
        begin
            out_valid_next   = 1'b1;
            out_load         = 1'b1;
            status_next      = dpdt_pkg::STATUS_OK;
            point_valid_next = rd_entry.z != 16'd0;
            x_um_next        = rd_entry.x;
            y_um_next        = rd_entry.y;
            z_mm_next        = rd_entry.z;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            ready_flag_reg <= 1'b0;
            rd_pending_reg <= 1'b0;
            out_valid_reg  <= 1'b0;
        end
        else
        begin
            ready_flag_reg <= ready_flag_next;
            rd_pending_reg <= rd_pending_next;
            out_valid_reg  <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (out_load)
        begin
            status_reg      <= status_next;
            point_valid_reg <= point_valid_next;
            x_um_reg        <= x_um_next;
            y_um_reg        <= y_um_next;
            z_mm_reg        <= z_mm_next;
        end
    end

    assign out_valid   = out_valid_reg;
    assign status      = status_reg;
    assign point_valid = point_valid_reg;
    assign x_um        = x_um_reg;
    assign y_um        = y_um_reg;
    assign z_mm        = z_mm_reg;

    // A query never overtakes a pending table write
    assert property (@(posedge clk) disable iff (!rst_n)
        query_take |-> !(|pix_valid_reg))
        else $error("query accepted with table writes pending");

    // A table read always lands in the result register next cycle
    assert property (@(posedge clk) disable iff (!rst_n)
        rd_pending_reg |=> out_valid_reg)
        else $error("table read result lost");

    // A read in flight never meets an untaken result
    assert property (@(posedge clk) disable iff (!rst_n)
        !(rd_pending_reg && out_valid_reg))
        else $error("table read overwrites waiting result");

    // A successful query has cleared the ready flag
    assert property (@(posedge clk) disable iff (!rst_n)
        rd_pending_reg |-> !ready_flag_reg)
        else $error("ready flag not cleared by query");

endmodule
